// ===== design/ivc_pkg.sv =====
// Shared types and constants of the interval overwrite visible count unit.
`default_nettype none
package ivc_pkg;

    localparam int DEF_TABLE_DEPTH = 512;
    localparam int DEF_MAX_POSTERS = 256;
    localparam int DEF_COORD_BITS  = 24;

    localparam int ID_W        = 8;
    localparam int VIS_W       = 9;
    localparam int STATUS_W    = 2;
    localparam int OWN_IDX_W   = 16;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_BAD_RANGE = 2'd2
    } status_t;

    // One increment or decrement of an owner's segment count.
    typedef struct packed {
        logic                 req;
        logic                 inc;
        logic [OWN_IDX_W-1:0] idx;
    } owner_cmd_t;

endpackage
`default_nettype wire

// ===== design/ivc_ram.sv =====
// Generic single write port, single read port RAM with registered read.
`default_nettype none
module ivc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== design/ivc_owner_unit.sv =====
// Per-owner segment counts and the count of owners still visible.
`default_nettype none
module ivc_owner_unit #(
    parameter int MAX_POSTERS = 256,
    parameter int TABLE_DEPTH = 512
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               clear,
    input  wire ivc_pkg::owner_cmd_t                cmd,
    output logic [$clog2(MAX_POSTERS+1)-1:0]        shown
);
    import ivc_pkg::*;

    localparam int OW  = $clog2(MAX_POSTERS);
    localparam int OCW = $clog2(TABLE_DEPTH + 1);
    localparam int SHW = $clog2(MAX_POSTERS + 1);

    logic [MAX_POSTERS-1:0] vbit_reg;
    logic                   pend_reg;
    logic                   inc_reg;
    logic [OW-1:0]          idx_reg;
    logic [SHW-1:0]         shown_reg;

    logic [OCW-1:0] rdata;
    logic [OCW-1:0] cnt;
    logic [OCW-1:0] cnt_next;

    ivc_ram #(.WIDTH(OCW), .DEPTH(MAX_POSTERS)) u_count_ram (
        .clk   (clk),
        .we    (pend_reg),
        .waddr (idx_reg),
        .wdata (cnt_next),
        .raddr (cmd.idx[OW-1:0]),
        .rdata (rdata)
    );

    // An owner whose valid bit is clear holds no segments.
    assign cnt = vbit_reg[idx_reg] ? rdata : '0;

    always_comb
    begin
        if (inc_reg)
        begin
            cnt_next = cnt + OCW'(1);
        end
        else if (cnt != '0)
        begin
            cnt_next = cnt - OCW'(1);
        end
        else
        begin
            cnt_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vbit_reg  <= '0;
            pend_reg  <= 1'b0;
            inc_reg   <= 1'b0;
            idx_reg   <= '0;
            shown_reg <= '0;
        end
        else
        begin
            pend_reg <= cmd.req;
            inc_reg  <= cmd.inc;
            idx_reg  <= cmd.idx[OW-1:0];
            if (clear)
            begin
                vbit_reg  <= '0;
                shown_reg <= '0;
            end
            else if (pend_reg)
            begin
                vbit_reg[idx_reg] <= 1'b1;
                if (inc_reg && cnt == '0)
                begin
                    shown_reg <= shown_reg + SHW'(1);
                end
                else if (!inc_reg && cnt == OCW'(1) && shown_reg != '0)
                begin
                    shown_reg <= shown_reg - SHW'(1);
                end
            end
        end
    end

    assign shown = shown_reg;

endmodule
`default_nettype wire

// ===== design/interval_overwrite_visible_count_unit.sv =====
// Top level of the interval overwrite visible count unit.
// Usage:
// - Input channel (in_valid / in_ready) carries one paint transaction: new_set, left,
//   right, poster_id. Output channel (out_valid / out_ready) returns one transaction
//   per paint: visible_count and status (ok, table full, bad range).
// - Each paint walks every slot of the segment table, in a read state and an evaluate
//   state per slot: read the slot, then trim, split or drop it. Each slot dropped by
//   an overlap adds a wait state and each inserted segment an insert and a wait state
//   for the read-modify-write of the owner count RAM. Before the walk, poster_id is
//   reduced by repeated subtraction of MAX_POSTERS when MAX_POSTERS is below 256.
// - in_ready is high only while idle; one paint is in flight at a time, and the next
//   transaction is taken at the earliest in the cycle after the result is loaded.
// - A finished result sits in the output register; if the receiver stalls, the
//   next paint is still accepted and computed, and waits at its end until the
//   output register frees.
// - After reset the table contents are unknown; the first paint walks the table
//   as if new_set were set, dropping every slot, so no separate clearing pass.
`default_nettype none
module interval_overwrite_visible_count_unit #(
    parameter int TABLE_DEPTH = ivc_pkg::DEF_TABLE_DEPTH,
    parameter int MAX_POSTERS = ivc_pkg::DEF_MAX_POSTERS,
    parameter int COORD_BITS  = ivc_pkg::DEF_COORD_BITS
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic                         new_set,
    input  wire logic [COORD_BITS-1:0]        left,
    input  wire logic [COORD_BITS-1:0]        right,
    input  wire logic [ivc_pkg::ID_W-1:0]     poster_id,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [ivc_pkg::VIS_W-1:0]         visible_count,
    output logic [ivc_pkg::STATUS_W-1:0]      status
);
    import ivc_pkg::*;

    localparam int SW   = $clog2(TABLE_DEPTH);
    localparam int CW   = $clog2(TABLE_DEPTH + 1);
    localparam int OW   = $clog2(MAX_POSTERS);
    localparam int SHW  = $clog2(MAX_POSTERS + 1);
    localparam int CB   = COORD_BITS;
    localparam int SEGW = 1 + 2 * CB + OW;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_RD,
        S_EVAL,
        S_OWN_WAIT,
        S_INS,
        S_DONE
    } state_t;

    state_t          state_reg, state_next;
    logic [SW-1:0]   k_reg, k_next;
    logic [CB-1:0]   l_reg, l_next;
    logic [CB-1:0]   r_reg, r_next;
    logic [ID_W-1:0] who_reg, who_next;
    logic            clr_reg, clr_next;
    logic            rst_clr_reg, rst_clr_next;
    status_t         st_reg, st_next;
    logic            ins_phase_reg, ins_phase_next;
    logic            has_lo_reg, has_lo_next;
    logic            has_hi_reg, has_hi_next;
    logic            main_reg, main_next;
    logic [CB-1:0]   lo_a_reg, lo_a_next, lo_b_reg, lo_b_next;
    logic [CB-1:0]   hi_a_reg, hi_a_next, hi_b_reg, hi_b_next;
    logic [OW-1:0]   lo_o_reg, lo_o_next, hi_o_reg, hi_o_next;
    logic [SW-1:0]   fs_reg [3];
    logic [SW-1:0]   fs_next [3];
    logic [1:0]      fs_cnt_reg, fs_cnt_next;
    logic [1:0]      ins_idx_reg, ins_idx_next;
    logic [CW-1:0]   vcnt_reg, vcnt_next;
    logic            out_valid_reg, out_valid_next;
    logic [VIS_W-1:0] vis_reg, vis_next;
    status_t         st_out_reg, st_out_next;

    logic            seg_we;
    logic [SW-1:0]   seg_waddr;
    logic [SEGW-1:0] seg_wdata;
    logic [SEGW-1:0] seg_rdata;

    logic            rd_v;
    logic [CB-1:0]   rd_a, rd_b;
    logic [OW-1:0]   rd_o;

    owner_cmd_t      own_cmd;
    logic            own_clear;
    logic [SHW-1:0]  shown;

    logic [CW:0]     vcnt_plus2;

    ivc_ram #(.WIDTH(SEGW), .DEPTH(TABLE_DEPTH)) u_seg_ram (
        .clk   (clk),
        .we    (seg_we),
        .waddr (seg_waddr),
        .wdata (seg_wdata),
        .raddr (k_reg),
        .rdata (seg_rdata)
    );

    ivc_owner_unit #(.MAX_POSTERS(MAX_POSTERS), .TABLE_DEPTH(TABLE_DEPTH)) u_owner (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (own_clear),
        .cmd   (own_cmd),
        .shown (shown)
    );

    assign {rd_v, rd_a, rd_b, rd_o} = seg_rdata;
    assign vcnt_plus2 = {1'b0, vcnt_reg} + (CW + 1)'(2);

    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        l_next         = l_reg;
        r_next         = r_reg;
        who_next       = who_reg;
        clr_next       = clr_reg;
        rst_clr_next   = rst_clr_reg;
        st_next        = st_reg;
        ins_phase_next = ins_phase_reg;
        has_lo_next    = has_lo_reg;
        has_hi_next    = has_hi_reg;
        main_next      = main_reg;
        lo_a_next      = lo_a_reg;
        lo_b_next      = lo_b_reg;
        lo_o_next      = lo_o_reg;
        hi_a_next      = hi_a_reg;
        hi_b_next      = hi_b_reg;
        hi_o_next      = hi_o_reg;
        fs_next        = fs_reg;
        fs_cnt_next    = fs_cnt_reg;
        ins_idx_next   = ins_idx_reg;
        vcnt_next      = vcnt_reg;
        vis_next       = vis_reg;
        st_out_next    = st_out_reg;
        out_valid_next = out_valid_reg && !out_ready;

        seg_we    = 1'b0;
        seg_waddr = k_reg;
        seg_wdata = '0;
        own_cmd   = '0;
        own_clear = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    l_next         = left;
                    r_next         = right;
                    who_next       = poster_id;
                    clr_next       = new_set || rst_clr_reg;
                    rst_clr_next   = 1'b0;
                    k_next         = '0;
                    fs_cnt_next    = '0;
                    ins_idx_next   = '0;
                    has_lo_next    = 1'b0;
                    has_hi_next    = 1'b0;
                    main_next      = 1'b1;
                    ins_phase_next = 1'b0;
                    if (new_set || rst_clr_reg)
                    begin
                        own_clear = 1'b1;
                        vcnt_next = '0;
                    end
                    if (left > right)
                    begin
                        st_next = ST_BAD_RANGE;
                    end
                    else if (!(new_set || rst_clr_reg) && vcnt_plus2 > (CW + 1)'(TABLE_DEPTH))
                    begin
                        st_next = ST_FULL;
                    end
                    else
                    begin
                        st_next = ST_OK;
                    end
                    state_next = S_MOD;
                end
            end

            S_MOD:
            begin
                // Reduce the owner id by repeated subtraction.
                if (32'(who_reg) >= 32'(MAX_POSTERS))
                begin
                    who_next = who_reg - ID_W'(MAX_POSTERS);
                end
                else
                begin
                    state_next = S_RD;
                end
            end

            S_RD:
            begin
                state_next = S_EVAL;
            end

            S_EVAL:
            begin
                state_next = S_RD;
                if (clr_reg || !rd_v)
                begin
                    // Slot is free, or dropped by the clearing walk.
                    if (clr_reg)
                    begin
                        seg_we = 1'b1;
                    end
                    if (fs_cnt_reg != 2'd3)
                    begin
                        fs_next[fs_cnt_reg] = k_reg;
                        fs_cnt_next         = fs_cnt_reg + 2'd1;
                    end
                end
                else if (st_reg == ST_OK && !(rd_a > r_reg) && !(rd_b < l_reg))
                begin
                    if (rd_a < l_reg)
                    begin
                        has_lo_next = 1'b1;
                        lo_a_next   = rd_a;
                        lo_b_next   = l_reg - CB'(1);
                        lo_o_next   = rd_o;
                    end
                    if (rd_b > r_reg)
                    begin
                        has_hi_next = 1'b1;
                        hi_a_next   = r_reg + CB'(1);
                        hi_b_next   = rd_b;
                        hi_o_next   = rd_o;
                    end
                    seg_we = 1'b1;
                    if (fs_cnt_reg != 2'd3)
                    begin
                        fs_next[fs_cnt_reg] = k_reg;
                        fs_cnt_next         = fs_cnt_reg + 2'd1;
                    end
                    vcnt_next   = vcnt_reg - CW'(1);
                    own_cmd.req = 1'b1;
                    own_cmd.inc = 1'b0;
                    own_cmd.idx = OWN_IDX_W'(rd_o);
                    state_next  = S_OWN_WAIT;
                end

                if (state_next == S_RD)
                begin
                    if (k_reg == SW'(TABLE_DEPTH - 1))
                    begin
                        ins_phase_next = 1'b1;
                        state_next     = (st_reg == ST_OK) ? S_INS : S_DONE;
                    end
                    else
                    begin
                        k_next = k_reg + SW'(1);
                    end
                end
            end

            S_OWN_WAIT:
            begin
                if (ins_phase_reg)
                begin
                    state_next = S_INS;
                end
                else if (k_reg == SW'(TABLE_DEPTH - 1))
                begin
                    ins_phase_next = 1'b1;
                    state_next     = (st_reg == ST_OK) ? S_INS : S_DONE;
                end
                else
                begin
                    k_next     = k_reg + SW'(1);
                    state_next = S_RD;
                end
            end

            S_INS:
            begin
                seg_waddr   = fs_reg[ins_idx_reg];
                own_cmd.inc = 1'b1;
                priority if (has_lo_reg)
                begin
                    seg_we      = 1'b1;
                    seg_wdata   = {1'b1, lo_a_reg, lo_b_reg, lo_o_reg};
                    own_cmd.req = 1'b1;
                    own_cmd.idx = OWN_IDX_W'(lo_o_reg);
                    has_lo_next = 1'b0;
                end
                else if (has_hi_reg)
                begin
                    seg_we      = 1'b1;
                    seg_wdata   = {1'b1, hi_a_reg, hi_b_reg, hi_o_reg};
                    own_cmd.req = 1'b1;
                    own_cmd.idx = OWN_IDX_W'(hi_o_reg);
                    has_hi_next = 1'b0;
                end
                else if (main_reg)
                begin
                    seg_we      = 1'b1;
                    seg_wdata   = {1'b1, l_reg, r_reg, OW'(who_reg)};
                    own_cmd.req = 1'b1;
                    own_cmd.idx = OWN_IDX_W'(who_reg);
                    main_next   = 1'b0;
                end
                if (seg_we)
                begin
                    ins_idx_next = ins_idx_reg + 2'd1;
                    vcnt_next    = vcnt_reg + CW'(1);
                    state_next   = S_OWN_WAIT;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                // Hold until the output register is free.
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    vis_next       = VIS_W'(shown);
                    st_out_next    = st_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rst_clr_reg   <= 1'b1;
            out_valid_reg <= 1'b0;
            vcnt_reg      <= '0;
            k_reg         <= '0;
            clr_reg       <= 1'b0;
            ins_phase_reg <= 1'b0;
            has_lo_reg    <= 1'b0;
            has_hi_reg    <= 1'b0;
            main_reg      <= 1'b0;
            fs_cnt_reg    <= '0;
            ins_idx_reg   <= '0;
            st_reg        <= ST_OK;
            st_out_reg    <= ST_OK;
            vis_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rst_clr_reg   <= rst_clr_next;
            out_valid_reg <= out_valid_next;
            vcnt_reg      <= vcnt_next;
            k_reg         <= k_next;
            clr_reg       <= clr_next;
            ins_phase_reg <= ins_phase_next;
            has_lo_reg    <= has_lo_next;
            has_hi_reg    <= has_hi_next;
            main_reg      <= main_next;
            fs_cnt_reg    <= fs_cnt_next;
            ins_idx_reg   <= ins_idx_next;
            st_reg        <= st_next;
            st_out_reg    <= st_out_next;
            vis_reg       <= vis_next;
        end
    end

    always_ff @(posedge clk)
    begin
        l_reg    <= l_next;
        r_reg    <= r_next;
        who_reg  <= who_next;
        lo_a_reg <= lo_a_next;
        lo_b_reg <= lo_b_next;
        lo_o_reg <= lo_o_next;
        hi_a_reg <= hi_a_next;
        hi_b_reg <= hi_b_next;
        hi_o_reg <= hi_o_next;
        fs_reg   <= fs_next;
    end

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign visible_count = vis_reg;
    assign status        = st_out_reg;

endmodule
`default_nettype wire

// ===== tb/interval_overwrite_visible_count_unit_tb.sv =====
// Testbench of the interval overwrite visible count unit: directed and random paints.
`timescale 1ns / 1ps
`default_nettype none
module interval_overwrite_visible_count_unit_tb;
    import ivc_pkg::*;

    localparam int DEPTH      = DEF_TABLE_DEPTH;
    localparam int POSTERS    = DEF_MAX_POSTERS;
    localparam int CW         = DEF_COORD_BITS;
    localparam logic [CW-1:0] CMAX = {CW{1'b1}};
    // Allow many times the slowest paint before calling it a hang.
    localparam longint CYCLE_LIMIT = 12_000_000;
    localparam int HOLD_LEN   = 4000;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            in_valid = 1'b0;
    logic            in_ready;
    logic            new_set = 1'b0;
    logic [CW-1:0]   left = '0;
    logic [CW-1:0]   right = '0;
    logic [ID_W-1:0] poster_id = '0;
    logic            out_valid;
    logic            out_ready = 1'b0;
    logic [VIS_W-1:0]    visible_count;
    logic [STATUS_W-1:0] status;

    typedef struct packed {
        logic [VIS_W-1:0] vis;
        status_t          st;
    } paint_result_t;

    paint_result_t result_q[$];

    // Shadow copy of the segment table and owner counts.
    logic [CW-1:0]   shadow_start [DEPTH];
    logic [CW-1:0]   shadow_end   [DEPTH];
    logic [ID_W-1:0] shadow_owner [DEPTH];
    bit              shadow_used  [DEPTH];
    int              owner_segs   [POSTERS];
    int              shown;

    int     send_idle = 0;
    int     recv_idle = 0;
    int     mismatches = 0;
    longint cycles = 0;
    logic   hold_go = 1'b0;
    int     hold_cnt = 0;
    wire    holding = hold_go && (hold_cnt < HOLD_LEN);

    interval_overwrite_visible_count_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .new_set(new_set), .left(left), .right(right), .poster_id(poster_id),
        .out_valid(out_valid), .out_ready(out_ready),
        .visible_count(visible_count), .status(status)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Abort on a hang.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Count the long receiver hold-off in its own process.
    always @(posedge clk)
    begin
        if (!hold_go)
            hold_cnt <= 0;
        else if (hold_cnt < HOLD_LEN)
            hold_cnt <= hold_cnt + 1;
    end

    function automatic void clear_shadow();
        for (int k = 0; k < DEPTH; k++)
            shadow_used[k] = 1'b0;
        for (int o = 0; o < POSTERS; o++)
            owner_segs[o] = 0;
        shown = 0;
    endfunction

    function automatic void drop_seg(int k);
        int o;
        o = shadow_owner[k];
        shadow_used[k] = 1'b0;
        if (owner_segs[o] > 0)
        begin
            owner_segs[o]--;
            if (owner_segs[o] == 0 && shown > 0)
                shown--;
        end
    endfunction

    function automatic void insert_seg(logic [CW-1:0] a, logic [CW-1:0] b, logic [ID_W-1:0] o);
        for (int k = 0; k < DEPTH; k++)
        begin
            if (!shadow_used[k])
            begin
                shadow_used[k]  = 1'b1;
                shadow_start[k] = a;
                shadow_end[k]   = b;
                shadow_owner[k] = o;
                if (owner_segs[o] == 0)
                    shown++;
                owner_segs[o]++;
                return;
            end
        end
    endfunction

    // Apply one paint to the shadow table and return what the block should report.
    function automatic paint_result_t paint_shadow(logic ns, logic [CW-1:0] l,
                                                   logic [CW-1:0] r, logic [ID_W-1:0] who);
        paint_result_t res;
        int free_cnt;
        bit has_lo, has_hi;
        logic [CW-1:0] lo_a, hi_b;
        logic [ID_W-1:0] lo_o, hi_o;
        free_cnt = 0;
        has_lo = 0;
        has_hi = 0;
        lo_a = '0; hi_b = '0; lo_o = '0; hi_o = '0;
        if (ns)
            clear_shadow();
        for (int k = 0; k < DEPTH; k++)
            if (!shadow_used[k])
                free_cnt++;
        if (l > r)
            res.st = ST_BAD_RANGE;
        else if (free_cnt < 2)
            res.st = ST_FULL;
        else
        begin
            res.st = ST_OK;
            for (int k = 0; k < DEPTH; k++)
            begin
                if (!shadow_used[k] || shadow_start[k] > r || shadow_end[k] < l)
                    continue;
                if (shadow_start[k] < l)
                begin
                    has_lo = 1;
                    lo_a = shadow_start[k];
                    lo_o = shadow_owner[k];
                end
                if (shadow_end[k] > r)
                begin
                    has_hi = 1;
                    hi_b = shadow_end[k];
                    hi_o = shadow_owner[k];
                end
                drop_seg(k);
            end
            if (has_lo)
                insert_seg(lo_a, l - 1'b1, lo_o);
            if (has_hi)
                insert_seg(r + 1'b1, hi_b, hi_o);
            insert_seg(l, r, who);
        end
        res.vis = VIS_W'(shown);
        return res;
    endfunction

    // Compare each result transaction with the oldest expectation; drive out_ready.
    always @(posedge clk)
    begin
        paint_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (result_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: visible_count=%0d status=%0d",
                             visible_count, status);
            end
            else
            begin
                want = result_q.pop_front();
                if (visible_count !== want.vis || status !== want.st)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: visible_count exp %0d got %0d, status exp %0d got %0d",
                                 want.vis, visible_count, want.st, status);
                end
            end
        end
        if (holding)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_idle);
    end

    // Offer one paint transaction; valid is left high so a back-to-back paint follows cleanly.
    task automatic send_paint(logic ns, logic [CW-1:0] l, logic [CW-1:0] r,
                              logic [ID_W-1:0] who);
        if ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle)
                @(posedge clk);
        end
        result_q = {result_q, paint_shadow(ns, l, r, who)};
        in_valid  <= 1'b1;
        new_set   <= ns;
        left      <= l;
        right     <= r;
        poster_id <= who;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Drop valid and wait until every expected result has arrived.
    task automatic drain();
        in_valid <= 1'b0;
        while (result_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic test_directed();
        send_paint(1'b0, 24'd10, 24'd20, 8'd1);     // first paint after reset
        send_paint(1'b0, 24'd0, 24'd0, 8'd0);       // left edge at zero
        send_paint(1'b0, 24'd14, 24'd16, 8'd2);     // split in the middle
        send_paint(1'b0, 24'd5, 24'd12, 8'd3);      // trim from the left
        send_paint(1'b0, 24'd18, 24'd30, 8'd4);     // trim from the right
        send_paint(1'b0, 24'd11, 24'd19, 8'd4);     // overwrite several
        send_paint(1'b0, CMAX, CMAX, 8'd255);       // top coordinate
        send_paint(1'b0, 24'd20, 24'd10, 8'd9);     // bad range
        send_paint(1'b0, CMAX, 24'd0, 8'd9);
        send_paint(1'b1, 24'd7, 24'd3, 8'd9);       // clear, then reject: table stays empty
        send_paint(1'b0, 24'd0, CMAX, 8'd255);      // whole axis
        send_paint(1'b0, 24'd1, CMAX - 1'b1, 8'd0);
        send_paint(1'b0, 24'd0, CMAX, 8'd0);        // same owner, all dropped
        send_paint(1'b1, 24'h555555, 24'haaaaaa, 8'haa);
        send_paint(1'b0, 24'haaaaaa, 24'hffffff, 8'h55);
        send_paint(1'b0, 24'h555555, 24'h555555, 8'h55);
        send_paint(1'b1, 24'd3, 24'd3, 8'd7);
        send_paint(1'b0, 24'd3, 24'd3, 8'd8);       // exact replace
        drain();
    endtask

    // Split one wide segment until fewer than two slots are free.
    task automatic test_table_full();
        send_paint(1'b1, 24'd0, CMAX, 8'd0);
        for (int i = 0; i < 258; i++)
            send_paint(1'b0, CW'(4 * i + 2), CW'(4 * i + 2), ID_W'(i + 1));
        send_paint(1'b0, 24'd9, 24'd8, 8'd1);       // bad range outranks full
        send_paint(1'b0, 24'd0, 24'd3, 8'd1);       // still full
        send_paint(1'b1, 24'd0, 24'd3, 8'd1);       // clear first, so accepted
        drain();
    endtask

    task automatic send_random();
        logic ns;
        logic [CW-1:0] a, b, t;
        logic [ID_W-1:0] who;
        int mode;
        ns = ($urandom_range(39) == 0);
        mode = $urandom_range(99);
        who = ($urandom_range(1) == 0) ? ID_W'($urandom_range(7)) : ID_W'($urandom_range(255));
        if (mode < 70)
        begin
            a = CW'($urandom_range(63));
            b = CW'($urandom_range(63));
        end
        else
        begin
            a = CW'($urandom());
            b = CW'($urandom());
        end
        // Mostly well-formed ranges; keep a few reversed ones.
        if (a > b && mode % 10 != 0)
        begin
            t = a; a = b; b = t;
        end
        send_paint(ns, a, b, who);
    endtask

    task automatic test_random();
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle = (ph == 0) ? 9 : (ph == 1) ? 46 : 0;
            recv_idle = (ph == 0) ? 46 : (ph == 1) ? 9 : 0;
            for (int i = 0; i < 280; i++)
                send_random();
            drain();
        end
    endtask

    // Hold the receiver off while paints keep coming, so the input stalls.
    task automatic test_backpressure();
        send_idle = 0;
        recv_idle = 0;
        hold_go <= 1'b1;
        for (int i = 0; i < 40; i++)
            send_random();
        hold_go <= 1'b0;
        drain();
    endtask

    initial
    begin
        send_idle = 9;
        recv_idle = 46;
        clear_shadow();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_table_full();
        test_random();
        test_backpressure();
        repeat (2200) @(posedge clk);
        if (mismatches == 0 && result_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
`default_nettype wire

// ===== sim.f =====
design/ivc_pkg.sv
design/ivc_ram.sv
design/ivc_owner_unit.sv
design/interval_overwrite_visible_count_unit.sv
tb/interval_overwrite_visible_count_unit_tb.sv
